// ===== src/mqcs_pkg.sv =====
// package for the multi-queue command scheduler
// types, function codes and status codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mqcs_pkg;
	localparam int NUM_QUEUES_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int DESC_W = 36;
	localparam logic [3:0] KIND_KERNEL = 4'd6;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_DISPATCH = 3'd1,
		FN_DONE = 3'd2,
		FN_CANCEL = 3'd3,
		FN_KFIN = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_LIMIT = 3'd1,
		ST_FULL = 3'd2,
		ST_NOT_PENDING = 3'd3,
		ST_UNKNOWN_KERNEL = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_BLOCKING = 1'd0,
		CFG_ACTIVE = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_CHECK,
		S_EMPTY,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== src/multi_queue_command_scheduler.sv =====
// multi-queue command scheduler: default queue plus round-robin concurrent queues
// top level with sequencer, per-queue counters and descriptor memory; uses mqcs_pkg
//
// usage:
//  s_axis carries one command transaction (func, queue, descriptor, kernel id, limit)
//  m_axis returns exactly one result transaction per command
//  cfg writes launch_blocking (index 0) or active_streams (index 1) while idle;
//  a pending config write holds s_axis_tready low
//  one command is handled at a time; s_axis_tready is low until its result
//  is taken by the receiver and the sequencer has returned to idle
//  with A active queues, push, cancel and rejected commands are decoded, then
//  a shared scan of queues 0..A, one per cycle, builds the all-empty flag
//  done adds the front read
//  dispatch and kernel-finished scan one queue per cycle, pausing for a read
//  and a check state on each front read from the descriptor memory; the worst
//  case is a kernel-finished search that reads every front
//  reset clears counters, heads, pending marks, the round-robin pointer and
//  the control registers; the command fields and descriptor memory are not cleared
//  a stalled receiver holds the result register and blocks new commands
`timescale 1ns / 1ps
`default_nettype none
module multi_queue_command_scheduler #(
	parameter int NUM_QUEUES = mqcs_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqcs_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// func[2:0], queue_index[6:3], command_kind[10:7], command_tag[26:11],
	// kernel_id[42:27], limit_hit[43], zero fill to 48 bits
	input wire logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// grant_valid[0], grant_queue[4:1], grant_kind[8:5], grant_tag[24:9],
	// grant_kernel_id[40:25], status[43:41], all_empty[44], zero fill to 48 bits
	output logic [47:0] m_axis_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [3:0] cfg_data
);
	localparam int NQ = NUM_QUEUES + 1;
	localparam int QW = $clog2(NQ + 1);
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NQ * QUEUE_DEPTH);

	mqcs_pkg::state_t state_q, state_d;

	logic [DW-1:0] head_q [NQ];
	logic [CW-1:0] count_q [NQ];
	logic [NQ-1:0] pend_q;
	logic [QW-1:0] last_q;
	logic blocking_q;
	logic [3:0] active_q;

	logic [2:0] func_q;
	logic [3:0] qi_q;
	logic [3:0] kind_q;
	logic [15:0] tag_q;
	logic [15:0] kid_q;
	logic limit_q;

	logic [QW-1:0] scan_q;
	logic [QW-1:0] left_q;
	logic found_q;
	logic [QW-1:0] sel_q;
	logic empty_q;
	logic gv_q;
	logic [3:0] gq_q;
	logic [35:0] gd_q;
	logic [2:0] status_q;

	logic [mqcs_pkg::DESC_W-1:0] mem [NQ * QUEUE_DEPTH];
	logic [mqcs_pkg::DESC_W-1:0] rd_q;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [CW:0] wr_slot;

	logic [QW-1:0] a_n;
	logic [QW-1:0] push_q;
	logic s_fire;
	logic m_fire;
	logic decode;

	assign a_n = (32'(active_q) > NUM_QUEUES) ? QW'(NUM_QUEUES) : QW'(active_q);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign cfg_ready = (state_q == mqcs_pkg::S_IDLE);
	// first scan cycle of a command decodes it
	assign decode = (sel_q != QW'(NQ));

	always_comb begin
		if (qi_q == 4'd0 || blocking_q || QW'(qi_q) > a_n || 32'(qi_q) > NUM_QUEUES)
			push_q = '0;
		else
			push_q = QW'(qi_q);
	end

	function automatic logic [QW-1:0] next_rr(input logic [QW-1:0] s, input logic [QW-1:0] a);
		next_rr = (s >= a) ? QW'(1) : s + QW'(1);
	endfunction

	// descriptor memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= {kind_q, tag_q, kid_q};
		rd_q <= mem[mem_ra];
	end

	// front address of the queue under scan, and tail write address of the push queue
	always_comb begin
		mem_ra = AW'(32'(scan_q) * QUEUE_DEPTH + 32'(head_q[scan_q]));
		wr_slot = (CW+1)'(head_q[push_q]) + (CW+1)'(count_q[push_q]);
		if (32'(wr_slot) >= QUEUE_DEPTH)
			wr_slot = wr_slot - (CW+1)'(QUEUE_DEPTH);
		mem_wa = AW'(32'(push_q) * QUEUE_DEPTH + 32'(wr_slot));
	end

	logic scan_ok;
	logic cand;
	always_comb begin
		scan_ok = (32'(scan_q) < NQ);
		cand = 1'b0;
		if (scan_ok) begin
			if (func_q == mqcs_pkg::FN_DISPATCH)
				cand = !pend_q[scan_q] && count_q[scan_q] != '0;
			else
				cand = pend_q[scan_q] && count_q[scan_q] != '0;
		end
	end

	logic match;
	assign match = (func_q == mqcs_pkg::FN_DISPATCH) ||
		(rd_q[35:32] == mqcs_pkg::KIND_KERNEL && rd_q[15:0] == kid_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mqcs_pkg::S_IDLE: if (s_fire) state_d = mqcs_pkg::S_SCAN;
			mqcs_pkg::S_SCAN: begin
				if (decode)
					state_d = mqcs_pkg::S_SCAN;
				else if (left_q == '0 || found_q)
					state_d = mqcs_pkg::S_EMPTY;
				else if (cand)
					state_d = mqcs_pkg::S_READ;
			end
			mqcs_pkg::S_READ: state_d = mqcs_pkg::S_CHECK;
			mqcs_pkg::S_CHECK: state_d = mqcs_pkg::S_SCAN;
			mqcs_pkg::S_EMPTY: if (scan_q >= a_n) state_d = mqcs_pkg::S_OUT;
			mqcs_pkg::S_OUT: if (m_fire) state_d = mqcs_pkg::S_IDLE;
			default: state_d = mqcs_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == mqcs_pkg::S_IDLE) && !cfg_valid;
		m_axis_tvalid = (state_q == mqcs_pkg::S_OUT);
		mem_we = 1'b0;
		if (state_q == mqcs_pkg::S_IDLE && s_fire)
			mem_we = 1'b0;
		if (state_q == mqcs_pkg::S_SCAN && func_q == mqcs_pkg::FN_PUSH && decode &&
			!limit_q && 32'(count_q[push_q]) < QUEUE_DEPTH)
			mem_we = 1'b1;
		m_axis_tdata = {3'b000, empty_q, status_q, gd_q[15:0], gd_q[31:16],
			gd_q[35:32], gq_q, gv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqcs_pkg::S_IDLE;
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
			pend_q <= '0;
			last_q <= '0;
			blocking_q <= 1'b0;
			active_q <= '0;
			scan_q <= '0;
			left_q <= '0;
			found_q <= 1'b0;
			sel_q <= '0;
			empty_q <= 1'b1;
			gv_q <= 1'b0;
			gq_q <= '0;
			gd_q <= '0;
			status_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mqcs_pkg::CFG_BLOCKING: blocking_q <= cfg_data[0];
					mqcs_pkg::CFG_ACTIVE: active_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				mqcs_pkg::S_IDLE: if (s_fire) begin
					found_q <= 1'b0;
					gv_q <= 1'b0;
					gq_q <= '0;
					gd_q <= '0;
					status_q <= mqcs_pkg::ST_OK;
					left_q <= '0;
					scan_q <= '0;
				end
				mqcs_pkg::S_SCAN: begin
					if (decode) begin
						// first visit: decode the command
						sel_q <= QW'(NQ);
						unique case (func_q)
							mqcs_pkg::FN_PUSH: begin
								if (limit_q)
									status_q <= mqcs_pkg::ST_LIMIT;
								else if (32'(count_q[push_q]) >= QUEUE_DEPTH)
									status_q <= mqcs_pkg::ST_FULL;
								else
									count_q[push_q] <= count_q[push_q] + CW'(1);
							end
							mqcs_pkg::FN_DISPATCH: begin
								if (count_q[0] != '0 && !pend_q[0]) begin
									scan_q <= '0;
									left_q <= QW'(1);
								end else if (a_n != '0) begin
									scan_q <= (last_q == '0 || last_q > a_n) ? QW'(1) :
										next_rr(last_q, a_n);
									left_q <= a_n;
								end
							end
							mqcs_pkg::FN_DONE, mqcs_pkg::FN_CANCEL: begin
								if (QW'(qi_q) > a_n || 32'(qi_q) >= NQ || !pend_q[qi_q])
									status_q <= mqcs_pkg::ST_NOT_PENDING;
								else if (func_q == mqcs_pkg::FN_CANCEL)
									pend_q[qi_q] <= 1'b0;
								else begin
									scan_q <= QW'(qi_q);
									left_q <= QW'(1);
								end
							end
							mqcs_pkg::FN_KFIN: begin
								if (kid_q != '0) begin
									status_q <= mqcs_pkg::ST_UNKNOWN_KERNEL;
									scan_q <= '0;
									left_q <= a_n + QW'(1);
								end
							end
							default: ;
						endcase
					end else if (left_q != '0 && !found_q) begin
						if (func_q == mqcs_pkg::FN_PUSH) begin
							left_q <= '0;
						end else if (func_q == mqcs_pkg::FN_DONE) begin
							if (!cand) begin
								pend_q[scan_q] <= 1'b0;
								left_q <= '0;
							end
						end else begin
							if (func_q == mqcs_pkg::FN_DISPATCH && scan_q != '0)
								last_q <= scan_q;
							if (!cand) begin
								left_q <= left_q - QW'(1);
								if (func_q == mqcs_pkg::FN_DISPATCH)
									scan_q <= next_rr(scan_q, a_n);
								else
									scan_q <= scan_q + QW'(1);
							end
						end
					end else begin
						scan_q <= '0;
						empty_q <= (count_q[0] == '0);
					end
				end
				mqcs_pkg::S_CHECK: begin
					if (match || func_q == mqcs_pkg::FN_DONE) begin
						found_q <= 1'b1;
						gv_q <= 1'b1;
						gq_q <= 4'(scan_q);
						gd_q <= rd_q;
						status_q <= mqcs_pkg::ST_OK;
						if (func_q == mqcs_pkg::FN_DISPATCH)
							pend_q[scan_q] <= 1'b1;
						else begin
							pend_q[scan_q] <= 1'b0;
							count_q[scan_q] <= count_q[scan_q] - CW'(1);
							head_q[scan_q] <= (32'(head_q[scan_q]) == QUEUE_DEPTH - 1) ? '0 :
								head_q[scan_q] + DW'(1);
						end
					end else begin
						left_q <= left_q - QW'(1);
						scan_q <= scan_q + QW'(1);
					end
				end
				mqcs_pkg::S_EMPTY: begin
					if (scan_q < a_n) begin
						scan_q <= scan_q + QW'(1);
						if (count_q[scan_q + QW'(1)] != '0)
							empty_q <= 1'b0;
					end
				end
				mqcs_pkg::S_OUT: if (m_fire) sel_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_q <= s_axis_tdata[2:0];
			qi_q <= s_axis_tdata[6:3];
			kind_q <= s_axis_tdata[10:7];
			tag_q <= s_axis_tdata[26:11];
			kid_q <= s_axis_tdata[42:27];
			limit_q <= s_axis_tdata[43];
		end
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");
	a_grant_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && gv_q && func_q == mqcs_pkg::FN_DISPATCH |-> pend_q[gq_q])
		else $error("dispatched queue not pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q[0]) <= QUEUE_DEPTH) else $error("default queue overfilled");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/multi_queue_command_scheduler_tb.sv =====
// self-checking testbench for multi_queue_command_scheduler
// predicts each result with a scoreboard class and drives stream and config ports; uses mqcs_pkg
`timescale 1ns / 1ps
module multi_queue_command_scheduler_tb;
	localparam int NQ = mqcs_pkg::NUM_QUEUES_DEF;
	localparam int DEPTH = mqcs_pkg::QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic gv;
		logic [3:0] gq;
		logic [3:0] gk;
		logic [15:0] gt;
		logic [15:0] gkid;
		logic [2:0] st;
		logic ae;
	} grant_t;

	class sched_scoreboard;
		logic [35:0] store [NQ+1][DEPTH];
		int head [NQ+1];
		int count [NQ+1];
		bit pending [NQ+1];
		int last_served;
		bit blocking;
		int active_raw;
		grant_t grants_due [$];
		int errors;
		int n_cmds, n_dispatched, n_retired, n_status [8];

		function new();
			for (int q = 0; q <= NQ; q++) begin
				head[q] = 0;
				count[q] = 0;
				pending[q] = 0;
			end
			last_served = 0;
			blocking = 0;
			active_raw = 0;
			errors = 0;
			n_cmds = 0;
			n_dispatched = 0;
			n_retired = 0;
			for (int i = 0; i < 8; i++) n_status[i] = 0;
		endfunction

		function int active();
			return active_raw > NQ ? NQ : active_raw;
		endfunction

		function void write_reg(logic idx, logic [3:0] val);
			if (mqcs_pkg::cfg_idx_t'(idx) == mqcs_pkg::CFG_BLOCKING) blocking = val[0];
			else active_raw = val;
		endfunction

		function void fill(ref grant_t g, input int q);
			logic [35:0] d;
			d = store[q][head[q]];
			g.gv = 1;
			g.gq = 4'(q);
			g.gk = d[35:32];
			g.gt = d[31:16];
			g.gkid = d[15:0];
		endfunction

		function void pop(int q);
			if (count[q] > 0) begin
				head[q] = (head[q] + 1) % DEPTH;
				count[q]--;
			end
			pending[q] = 0;
		endfunction

		// kernel id of a randomly picked pending kernel front, or zero when none is picked
		function logic [15:0] busy_kernel();
			for (int q = 0; q <= active(); q++)
				if (pending[q] && count[q] > 0
						&& store[q][head[q]][35:32] == mqcs_pkg::KIND_KERNEL
						&& $urandom_range(0, 1))
					return store[q][head[q]][15:0];
			return 16'd0;
		endfunction

		function void note_command(logic [47:0] d);
			logic [2:0] fn;
			int qi, a, q, s;
			logic [3:0] kind;
			logic [15:0] tag, kid;
			grant_t g;
			fn = d[2:0];
			qi = d[6:3];
			kind = d[10:7];
			tag = d[26:11];
			kid = d[42:27];
			a = active();
			g = '0;
			g.st = mqcs_pkg::ST_OK;
			n_cmds++;
			case (fn)
				mqcs_pkg::FN_PUSH: begin
					q = (qi == 0 || blocking || qi > a) ? 0 : qi;
					if (d[43]) g.st = mqcs_pkg::ST_LIMIT;
					else if (count[q] >= DEPTH) g.st = mqcs_pkg::ST_FULL;
					else begin
						store[q][(head[q] + count[q]) % DEPTH] = {kind, tag, kid};
						count[q]++;
					end
				end
				mqcs_pkg::FN_DISPATCH: begin
					if (count[0] > 0 && !pending[0]) begin
						pending[0] = 1;
						fill(g, 0);
					end else if (a > 0) begin
						s = (last_served == 0 || last_served > a) ? 1 : (last_served % a) + 1;
						for (int i = 0; i < a; i++) begin
							last_served = s;
							if (!pending[s] && count[s] > 0) begin
								pending[s] = 1;
								fill(g, s);
								break;
							end
							s = (s % a) + 1;
						end
					end
					if (g.gv) n_dispatched++;
				end
				mqcs_pkg::FN_DONE, mqcs_pkg::FN_CANCEL: begin
					if (qi > a || !pending[qi]) g.st = mqcs_pkg::ST_NOT_PENDING;
					else if (mqcs_pkg::func_t'(fn) == mqcs_pkg::FN_DONE) begin
						if (count[qi] > 0) fill(g, qi);
						pop(qi);
						n_retired++;
					end else pending[qi] = 0;
				end
				mqcs_pkg::FN_KFIN: begin
					if (kid != 0) begin
						g.st = mqcs_pkg::ST_UNKNOWN_KERNEL;
						for (q = 0; q <= a; q++) begin
							if (pending[q] && count[q] > 0
									&& store[q][head[q]][35:32] == mqcs_pkg::KIND_KERNEL
									&& store[q][head[q]][15:0] == kid) begin
								fill(g, q);
								pop(q);
								g.st = mqcs_pkg::ST_OK;
								n_retired++;
								break;
							end
						end
					end
				end
				default: ;
			endcase
			g.ae = 1;
			for (q = 0; q <= a; q++)
				if (count[q] > 0) g.ae = 0;
			n_status[g.st]++;
			grants_due.insert(grants_due.size(), g);
		endfunction

		function void check_result(logic [47:0] d);
			grant_t e, r;
			r.gv = d[0];
			r.gq = d[4:1];
			r.gk = d[8:5];
			r.gt = d[24:9];
			r.gkid = d[40:25];
			r.st = d[43:41];
			r.ae = d[44];
			if (grants_due.size() == 0) begin
				$error("result transaction with no command outstanding: %h", d);
				errors++;
				return;
			end
			e = grants_due[0];
			grants_due.delete(0);
			if (r.gv !== e.gv) begin
				$error("grant_valid expected %0d actual %0d", e.gv, r.gv);
				errors++;
			end
			if (r.gq !== e.gq) begin
				$error("grant_queue expected %0d actual %0d", e.gq, r.gq);
				errors++;
			end
			if (r.gk !== e.gk) begin
				$error("grant_kind expected %0d actual %0d", e.gk, r.gk);
				errors++;
			end
			if (r.gt !== e.gt) begin
				$error("grant_tag expected %h actual %h", e.gt, r.gt);
				errors++;
			end
			if (r.gkid !== e.gkid) begin
				$error("grant_kernel_id expected %h actual %h", e.gkid, r.gkid);
				errors++;
			end
			if (r.st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, r.st);
				errors++;
			end
			if (r.ae !== e.ae) begin
				$error("all_empty expected %0d actual %0d", e.ae, r.ae);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	sched_scoreboard sb = new();
	bit idle_en = 1;
	bit long_hold = 0;
	int quiet_cycles = 0;

	multi_queue_command_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// monitors and stall watchdog
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
		if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("multi_queue_command_scheduler test failed");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	function automatic logic [47:0] pack_cmd(logic [2:0] fn, logic [3:0] qi, logic [3:0] kind,
			logic [15:0] tag, logic [15:0] kid, logic lim);
		return {4'd0, lim, kid, tag, kind, qi, fn};
	endfunction

	task automatic send_cmd(logic [47:0] d);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(mqcs_pkg::cfg_idx_t idx, logic [3:0] val);
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic random_cmd();
		int r, a;
		logic [3:0] qi, kind;
		logic [15:0] kid, bk;
		a = sb.active();
		r = $urandom_range(0, 99);
		qi = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, a));
		kind = ($urandom_range(0, 2) == 0) ? mqcs_pkg::KIND_KERNEL : 4'($urandom_range(0, 15));
		kid = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
		if (r < 32)
			send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, qi, kind, 16'($urandom), kid,
				$urandom_range(0, 19) == 0));
		else if (r < 57)
			send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, qi, kind, 16'($urandom), kid,
				$urandom_range(0, 1)));
		else if (r < 73)
			send_cmd(pack_cmd(mqcs_pkg::FN_DONE, qi, kind, 16'($urandom), kid,
				$urandom_range(0, 1)));
		else if (r < 81)
			send_cmd(pack_cmd(mqcs_pkg::FN_CANCEL, qi, kind, 16'($urandom), kid,
				$urandom_range(0, 1)));
		else if (r < 96) begin
			bk = sb.busy_kernel();
			if ($urandom_range(0, 3) != 0 && bk != 0) kid = bk;
			else if ($urandom_range(0, 5) == 0) kid = 16'd0;
			send_cmd(pack_cmd(mqcs_pkg::FN_KFIN, qi, kind, 16'($urandom), kid,
				$urandom_range(0, 1)));
		end else
			send_cmd(pack_cmd(3'($urandom_range(5, 7)), qi, kind, 16'($urandom), kid,
				$urandom_range(0, 1)));
	endtask

	initial begin
		logic [3:0] act_set [6] = '{4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};
		logic [3:0] blk_set [6] = '{4'd0, 4'd1, 4'd0, 4'd0, 4'd14, 4'd0};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(mqcs_pkg::CFG_ACTIVE, 4'd8);

		// directed: routing, limit, dispatch order, done/cancel edge cases, kernel search
		send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd0, mqcs_pkg::KIND_KERNEL, 16'h1234, 16'd5, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd1, 4'd1, 16'h0000, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd8, 4'd8, 16'hffff, 16'hffff, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd2, mqcs_pkg::KIND_KERNEL, 16'haaaa, 16'd9, 1'b1));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd15, 4'd15, 16'h5555, 16'd7, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_PUSH, 4'd2, mqcs_pkg::KIND_KERNEL, 16'h00ff, 16'd9, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DISPATCH, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DONE, 4'd3, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_CANCEL, 4'd9, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_DONE, 4'd1, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_CANCEL, 4'd8, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_KFIN, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_KFIN, 4'd0, 4'd0, 16'd0, 16'd77, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_KFIN, 4'd0, 4'd0, 16'd0, 16'd5, 1'b0));
		send_cmd(pack_cmd(mqcs_pkg::FN_KFIN, 4'd0, 4'd0, 16'd0, 16'd9, 1'b0));
		send_cmd(pack_cmd(3'd5, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(3'd6, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0));
		send_cmd(pack_cmd(3'd7, 4'd15, 4'd15, 16'hffff, 16'hffff, 1'b1));

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(mqcs_pkg::CFG_BLOCKING, blk_set[ph]);
			write_reg(mqcs_pkg::CFG_ACTIVE, act_set[ph]);
			if (ph == 5) idle_en = 0;
			for (int n = 0; n < 230; n++) begin
				if (ph == 2 && n == 100) long_hold = 1;
				random_cmd();
			end
		end
		s_axis_tvalid <= 0;

		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("ran %0d commands: %0d dispatched, %0d retired", sb.n_cmds, sb.n_dispatched,
			sb.n_retired);
		$display("status counts ok/limit/full/not-pending/unknown: %0d %0d %0d %0d %0d",
			sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3], sb.n_status[4]);
		if (sb.errors == 0)
			$display("multi_queue_command_scheduler test passed");
		else
			$display("multi_queue_command_scheduler test failed");
		$finish;
	end
endmodule
